// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lweb_pkg.sv =====
// ----------------------------------------------------------------------------
// lweb_pkg
// Shared types, constants and the gamma weight table for the exposure blend.
// ----------------------------------------------------------------------------
package lweb_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int WEIGHT_W   = 17;
    localparam int WT_DEPTH   = 256;
    localparam int WT_ADDR_W  = 8;
    localparam int FILL_CNT_W = WT_ADDR_W + 1;

    // BT.601 luma weights, 16-bit fixed point
    localparam logic [23:0] LUMA_COEF_R = 24'd19595;
    localparam logic [23:0] LUMA_COEF_G = 24'd38469;
    localparam logic [23:0] LUMA_COEF_B = 24'd7472;
    localparam logic [23:0] ROUND_HALF  = 24'd32768;

    localparam int unsigned WEIGHT_ONE = 32'd65536;
    localparam int unsigned CUBE_255   = 32'd16581375;

    typedef logic [WEIGHT_W-1:0]                weight_t;
    typedef logic [WT_DEPTH-1:0][WEIGHT_W-1:0]  weight_rom_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]    pixel_t;

    // Write request from the table loader into the weight memory
    typedef struct packed {
        logic                 we;
        logic [WT_ADDR_W-1:0] addr;
        weight_t              data;
        logic                 done;
    } fill_wr_t;

    // round(65536 * (l/255)^0.3), half up, by exact integer comparison:
    // the largest w with (2w-1)^10 * 255^3 <= l^3 * 2^170.
    function automatic weight_t weight_entry(input int unsigned l);
        logic [207:0] rhs;
        logic [207:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        begin
            rhs = 208'(l * l * l) << 170;
            lo  = 0;
            hi  = WEIGHT_ONE;
            for (int it = 0; it < 18; it++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 1) >> 1;
                    lhs = 208'd1;
                    for (int k = 0; k < 10; k++)
                    begin
                        lhs = lhs * 208'(2 * mid - 1);
                    end
                    lhs = lhs * 208'(CUBE_255);
                    if (lhs <= rhs)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
            end
            return WEIGHT_W'(lo);
        end
    endfunction

    function automatic weight_rom_t build_weight_rom();
        weight_rom_t rom;
        begin
            for (int l = 0; l < WT_DEPTH; l++)
            begin
                rom[l] = weight_entry(l);
            end
            return rom;
        end
    endfunction

    localparam weight_rom_t WEIGHT_ROM = build_weight_rom();

endpackage

// ===== rtl/lweb_ram.sv =====
// ----------------------------------------------------------------------------
// lweb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lweb_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lweb_fill.sv =====
// ----------------------------------------------------------------------------
// lweb_fill
// Loads the gamma weight curve into the weight memory after reset.
// ----------------------------------------------------------------------------
module lweb_fill import lweb_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    output fill_wr_t fill
);

    logic [FILL_CNT_W-1:0] cnt_reg;
    logic [FILL_CNT_W-1:0] cnt_next;

    // top bit set once every entry has been written
    assign cnt_next = cnt_reg[WT_ADDR_W] ? cnt_reg : cnt_reg + FILL_CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign fill.we   = !cnt_reg[WT_ADDR_W];
    assign fill.addr = cnt_reg[WT_ADDR_W-1:0];
    assign fill.data = WEIGHT_ROM[cnt_reg[WT_ADDR_W-1:0]];
    assign fill.done = cnt_reg[WT_ADDR_W];

endmodule

// ===== rtl/lweb_blend.sv =====
// ----------------------------------------------------------------------------
// lweb_blend
// One channel lane: (a*w + b*(65536-w) + 32768) >> 16, as b + (a-b)*w.
// ----------------------------------------------------------------------------
module lweb_blend import lweb_pkg::*; (
    input  logic [CHAN_W-1:0] a,
    input  logic [CHAN_W-1:0] b,
    input  weight_t           w,
    output logic [CHAN_W-1:0] v
);

    logic signed [CHAN_W:0]   diff;
    logic signed [25:0]       prod;
    logic signed [25:0]       sum;

    assign diff = $signed({1'b0, a}) - $signed({1'b0, b});
    assign prod = 26'(diff) * $signed({9'b0, w});
    assign sum  = $signed({2'b0, b, 16'b0}) + prod + $signed(26'(ROUND_HALF));
    // sum stays within 0 .. 255*65536+32768
    assign v    = sum[23:16];

endmodule

// ===== rtl/luma_weighted_exposure_blend_top.sv =====
// ----------------------------------------------------------------------------
// luma_weighted_exposure_blend_top
// Two-exposure pixel fusion weighted by a gamma 0.3 curve of first-pixel luma.
// ----------------------------------------------------------------------------
// Takes one pair of co-located RGB pixels per clock and returns one fused
// pixel per pair, in order. After reset the block loads the weight curve
// into its weight memory, one entry per cycle, and holds s_axis_tready low
// until that load is done. From then on it sustains one request per clock
// while the output side accepts. A request passes three register stages:
// the luma stage, the weight memory read (registered) and the blend stage
// into the output register, and output valid rises once it is there. Each
// stage advances on its own when the stage after it is free, so a stalled
// output still lets up to two more pixel pairs in.
// ----------------------------------------------------------------------------
module luma_weighted_exposure_blend_top import lweb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] first_red, [15:8] first_green, [23:16] first_blue,
    // [31:24] second_red, [39:32] second_green, [47:40] second_blue
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] fused_red, [15:8] fused_green, [23:16] fused_blue
    output logic [23:0] m_axis_tdata
);

    fill_wr_t fill;

    // stage 1: luma and pixel pair
    logic                 s1_valid_reg;
    logic [WT_ADDR_W-1:0] s1_luma_reg;
    pixel_t               s1_first_reg;
    pixel_t               s1_second_reg;

    // stage 2: weight read in flight
    logic                 s2_valid_reg;
    pixel_t               s2_first_reg;
    pixel_t               s2_second_reg;

    // output register
    logic                 out_valid_reg;
    pixel_t               out_pix_reg;

    pixel_t               in_first;
    pixel_t               in_second;
    logic [23:0]          luma_sum;
    weight_t              weight;
    pixel_t               blend_pix;

    logic                 accept;
    logic                 s1_to_s2;
    logic                 s2_to_out;

    // ---------------------------------------------------------------------
    // Handshake: each stage advances when the next one is empty or draining
    // ---------------------------------------------------------------------
    assign s2_to_out     = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s1_to_s2      = s1_valid_reg && (!s2_valid_reg || s2_to_out);
    assign s_axis_tready = fill.done && (!s1_valid_reg || s1_to_s2);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------------
    // Unpack the request
    // ---------------------------------------------------------------------
    assign in_first  = s_axis_tdata[23:0];
    assign in_second = s_axis_tdata[47:24];

    // BT.601 luma of the first pixel; never above 255
    assign luma_sum = {16'b0, in_first[0]} * LUMA_COEF_R
                    + {16'b0, in_first[1]} * LUMA_COEF_G
                    + {16'b0, in_first[2]} * LUMA_COEF_B
                    + ROUND_HALF;

    // ---------------------------------------------------------------------
    // Weight table loader and memory
    // ---------------------------------------------------------------------
    lweb_fill u_fill (
        .clk   (clk),
        .rst_n (rst_n),
        .fill  (fill)
    );

    // read is issued as stage 1 moves into stage 2, so the data lines up
    // with stage 2 and holds while stage 2 stalls
    lweb_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (WT_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (fill.we),
        .waddr (fill.addr),
        .wdata (fill.data),
        .re    (s1_to_s2),
        .raddr (s1_luma_reg),
        .rdata (weight)
    );

    // ---------------------------------------------------------------------
    // Blend lanes, one per channel
    // ---------------------------------------------------------------------
    for (genvar c = 0; c < NUM_CHAN; c++)
    begin : g_lane
        lweb_blend u_blend (
            .a (s2_first_reg[c]),
            .b (s2_second_reg[c]),
            .w (weight),
            .v (blend_pix[c])
        );
    end

    // ---------------------------------------------------------------------
    // Control: valid bits
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_to_s2)
                s1_valid_reg <= 1'b0;

            if (s1_to_s2)
                s2_valid_reg <= 1'b1;
            else if (s2_to_out)
                s2_valid_reg <= 1'b0;

            if (s2_to_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Payload: load on advance, hold otherwise
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_luma_reg   <= luma_sum[23:16];
            s1_first_reg  <= in_first;
            s1_second_reg <= in_second;
        end
        if (s1_to_s2)
        begin
            s2_first_reg  <= s1_first_reg;
            s2_second_reg <= s1_second_reg;
        end
        if (s2_to_out)
            out_pix_reg <= blend_pix;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;

endmodule

// ===== rtl/lweb_checker.sv =====
// ----------------------------------------------------------------------------
// lweb_checker
// Port-level checks on the exposure blend: requests in flight, depth and hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lweb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    logic       in_fire;
    logic       out_fire;
    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_fire && !out_fire)
            inflight_next = inflight_reg + 3'd1;
        else if (out_fire && !in_fire)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // no result without an outstanding request
    `ASSERT_IMPLIES(a_no_orphan, clk, rst_n, m_axis_tvalid, inflight_reg != 3'd0)

    // three stages deep: never more than three requests in flight
    `ASSERT_IMPLIES(a_depth, clk, rst_n, in_fire, inflight_reg <= 3'd2 || out_fire)

    // a full pipe with a stalled output takes nothing in
    `ASSERT_IMPLIES(a_full_stall, clk, rst_n, inflight_reg == 3'd3 && !m_axis_tready, !s_axis_tready)

endmodule

bind luma_weighted_exposure_blend_top lweb_checker u_lweb_checker (.*);

// ===== tb/sv/luma_weighted_exposure_blend_checker.sv =====
// ----------------------------------------------------------------------------
// luma_weighted_exposure_blend_checker
// Watches both stream channels, predicts each fused pixel and compares it.
// ----------------------------------------------------------------------------
// The gamma weight curve is rebuilt here: a floating-point first guess per
// luma level, then corrected by an exact integer test of the half-up
// rounding boundary. Expected pixels wait in order until the output side
// accepts a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module luma_weighted_exposure_blend_checker import lweb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int unsigned fused_pending,
    output int unsigned mismatch_count
);

    localparam int unsigned LUMA_R   = 19595;
    localparam int unsigned LUMA_G   = 38469;
    localparam int unsigned LUMA_B   = 7472;
    localparam int unsigned HALF_LSB = 32768;

    weight_t gamma_wt [WT_DEPTH];
    pixel_t  fused_q [$];

    // True when w - 1/2 <= 65536 * (l/255)^0.3, tested exactly in integers:
    // (2w-1)^10 * 255^3 <= l^3 * 2^170. Needs w >= 1.
    function automatic bit below_curve(int unsigned l, int unsigned w);
        logic [255:0] lhs;
        logic [255:0] rhs;
        begin
            lhs = 256'd1;
            for (int k = 0; k < 10; k++)
            begin
                lhs = lhs * 256'(2 * w - 1);
            end
            lhs = lhs * 256'(CUBE_255);
            rhs = 256'(l * l * l) << 170;
            return lhs <= rhs;
        end
    endfunction

    function automatic weight_t curve_weight(int unsigned l);
        real         guess;
        int unsigned w;
        begin
            guess = 65536.0 * $pow(real'(l) / 255.0, 0.3) + 0.5;
            w     = $rtoi(guess);
            if (w > WEIGHT_ONE)
                w = WEIGHT_ONE;
            // nudge the float guess onto the exact rounding boundary
            while (w < WEIGHT_ONE && below_curve(l, w + 1))
                w++;
            while (w > 0 && !below_curve(l, w))
                w--;
            return weight_t'(w);
        end
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, weight_t w);
        int unsigned ua;
        int unsigned ub;
        int unsigned uw;
        int unsigned v;
        begin
            ua = a;
            ub = b;
            uw = w;
            v  = (ua * uw + ub * (WEIGHT_ONE - uw) + HALF_LSB) >> 16;
            return v[7:0];
        end
    endfunction

    function automatic pixel_t fuse_pixels(pixel_t p1, pixel_t p2);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned luma;
        weight_t     w;
        pixel_t      res;
        begin
            r    = p1[0];
            g    = p1[1];
            b    = p1[2];
            luma = ((r * LUMA_R + g * LUMA_G + b * LUMA_B + HALF_LSB) >> 16) & 32'hFF;
            w    = gamma_wt[luma];
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                res[c] = mix_channel(p1[c], p2[c], w);
            end
            return res;
        end
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        begin
            $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
            mismatch_count++;
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        fused_pending  = 0;
        for (int l = 0; l < WT_DEPTH; l++)
        begin
            gamma_wt[l] = curve_weight(l);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        string  chan_name [NUM_CHAN];
        chan_name[0] = "fused_red";
        chan_name[1] = "fused_green";
        chan_name[2] = "fused_blue";
        if (rst_n)
        begin
            // pop before push: a result never overtakes its own request
            if (m_tvalid && m_tready)
            begin
                if (fused_q.size() == 0)
                begin
                    report_mismatch("fused pixel with no request waiting", m_tdata, 0);
                end
                else
                begin
                    want = fused_q.pop_front();
                    for (int c = 0; c < NUM_CHAN; c++)
                    begin
                        if (m_tdata[c*8 +: 8] !== want[c])
                            report_mismatch(chan_name[c], m_tdata[c*8 +: 8], want[c]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                fused_q.push_back(fuse_pixels(s_tdata[23:0], s_tdata[47:24]));
            fused_pending = fused_q.size();
        end
    end

endmodule

// ===== tb/sv/luma_weighted_exposure_blend_top_tb.sv =====
// ----------------------------------------------------------------------------
// luma_weighted_exposure_blend_top_tb
// Stream-level test of the two-exposure luma-weighted pixel blend.
// ----------------------------------------------------------------------------
// Feeds pixel pairs into the block: a short directed set of corner pixels,
// then about nineteen hundred random pairs in segments with varying idle
// rates on both sides. One segment holds the output off for a long stretch
// so the pipeline fills and stalls its input; at mid-run the sender drains
// the block completely. A separate checker predicts and compares each fused
// pixel; this module only drives traffic and calls the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module luma_weighted_exposure_blend_top_tb;
    import lweb_pkg::*;

    // The longest quiet stretches are the weight memory load after reset and the
    // long output hold. Allow several times the worst quiet stretch.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned SEG_COUNT      = 19;
    localparam int unsigned SEG_ITEMS      = 100;
    localparam int unsigned PRESSURE_SEG   = 5;
    localparam int unsigned DRAIN_SEG      = 10;
    localparam int unsigned TAIL_CYCLES    = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] first_red, [15:8] first_green, [23:16] first_blue,
    // [31:24] second_red, [39:32] second_green, [47:40] second_blue
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] fused_red, [15:8] fused_green, [23:16] fused_blue
    logic [23:0] m_axis_tdata;

    int unsigned fused_pending;
    int unsigned mismatch_count;

    // Knobs for the request sender and the output receiver
    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;
    bit          hold_req;

    int unsigned quiet_cycles;

    luma_weighted_exposure_blend_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    luma_weighted_exposure_blend_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .fused_pending  (fused_pending),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic pixel_t rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_t p;
        begin
            p[0] = r;
            p[1] = g;
            p[2] = b;
            return p;
        end
    endfunction

    // Lean toward the channel extremes so saturated blends show up often
    function automatic logic [7:0] pick_chan();
        int unsigned sel;
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                return 8'd0;
            else if (sel == 1)
                return 8'd255;
            else
                return 8'($urandom_range(0, 255));
        end
    endfunction

    // Present one pixel pair at the falling edge; hold it until accepted
    task automatic send_pair(pixel_t p1, pixel_t p2);
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b1;
            s_axis_tdata  = {p2, p1};
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    // Drop valid for a burst of random length, with junk on the data lines
    task automatic maybe_gap();
        int unsigned len;
        begin
            if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct)
            begin
                len = $urandom_range(1, 19);
                @(negedge clk);
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = 48'({$urandom, $urandom});
                repeat (len - 1) @(negedge clk);
            end
        end
    endtask

    // Stop offering requests and wait until every fused pixel is back
    task automatic drain_block();
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            while (fused_pending != 0)
                @(negedge clk);
        end
    endtask

    task automatic send_random_pair();
        pixel_t      p1;
        pixel_t      p2;
        logic [7:0]  gray;
        int unsigned kind;
        begin
            kind = $urandom_range(0, 19);
            p1   = rgb(pick_chan(), pick_chan(), pick_chan());
            p2   = rgb(pick_chan(), pick_chan(), pick_chan());
            if (kind < 3)
            begin
                // gray first pixel: pick a luma index anywhere on the whole curve
                gray = 8'($urandom_range(0, 255));
                p1   = rgb(gray, gray, gray);
            end
            else if (kind == 3)
                p2 = p1;
            else if (kind == 4)
                p2 = ~p1;
            send_pair(p1, p2);
        end
    endtask

    // Output receiver: random stall bursts, plus one long hold on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither side accepts a request
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL luma_weighted_exposure_blend_top");
            $finish;
        end
    end

    initial
    begin
        int unsigned pct_menu [4];
        pct_menu[0]    = 0;
        pct_menu[1]    = 3;
        pct_menu[2]    = 10;
        pct_menu[3]    = 25;
        quiet_cycles   = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed corners; the first request also waits out the table load
        send_pair(rgb(0, 0, 0), rgb(0, 0, 0));
        send_pair(rgb(255, 255, 255), rgb(255, 255, 255));
        // zero luma gives zero weight: pass the second pixel through
        send_pair(rgb(0, 0, 0), rgb(255, 255, 255));
        // full luma gives full weight: pass the first pixel through
        send_pair(rgb(255, 255, 255), rgb(0, 0, 0));
        send_pair(rgb(255, 0, 0), rgb(0, 255, 255));
        send_pair(rgb(0, 255, 0), rgb(255, 0, 255));
        send_pair(rgb(0, 0, 255), rgb(255, 255, 0));
        send_pair(rgb(0, 0, 1), rgb(255, 255, 255));
        send_pair(rgb(1, 1, 1), rgb(255, 255, 255));
        send_pair(rgb(254, 254, 254), rgb(0, 0, 0));
        send_pair(rgb(255, 255, 254), rgb(0, 0, 0));
        send_pair(rgb(128, 128, 128), rgb(0, 0, 0));
        send_pair(rgb(8'hAA, 8'hAA, 8'hAA), rgb(8'h55, 8'h55, 8'h55));
        send_pair(rgb(8'h55, 8'h55, 8'h55), rgb(8'hAA, 8'hAA, 8'hAA));
        send_pair(rgb(0, 0, 0), rgb(255, 0, 128));
        send_pair(rgb(100, 200, 50), rgb(250, 10, 180));

        // Random segments with varying idle rates; the last one runs flat out
        for (int seg = 0; seg < SEG_COUNT; seg++)
        begin
            if (seg == SEG_COUNT - 1 || seg == PRESSURE_SEG)
            begin
                send_idle_pct  = 0;
                sink_stall_pct = (seg == PRESSURE_SEG) ? 10 : 0;
            end
            else
            begin
                send_idle_pct  = pct_menu[$urandom_range(0, 3)];
                sink_stall_pct = pct_menu[$urandom_range(0, 3)];
            end
            if (seg == DRAIN_SEG)
                drain_block();
            if (seg == PRESSURE_SEG)
                hold_req = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                maybe_gap();
                send_random_pair();
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS luma_weighted_exposure_blend_top");
        else
            $display("FAIL luma_weighted_exposure_blend_top");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lweb_pkg.sv
rtl/lweb_ram.sv
rtl/lweb_fill.sv
rtl/lweb_blend.sv
rtl/luma_weighted_exposure_blend_top.sv
rtl/lweb_checker.sv
tb/sv/luma_weighted_exposure_blend_checker.sv
tb/sv/luma_weighted_exposure_blend_top_tb.sv
